// ===== rtl/json_key_uint_extractor_assert.svh =====
// Assertion macros for the JSON key extractor; empty when SYNTHESIS is defined.
`ifndef JSON_KEY_UINT_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_UINT_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define JKUE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jkue assertion failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define JKUE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jkue assertion failed");
`else
`define JKUE_ASSERT_IMPLY(label, ante, cons)
`define JKUE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/jkue_pkg.sv =====
// Shared types, constants and character helpers for the JSON key extractor.
package jkue_pkg;

   localparam int TextW  = 8;
   localparam int ValueW = 32;
   localparam int MatchW = 5;
   localparam int KeyLen = 16;

   localparam logic [TextW-1:0] ChNul   = 8'h00;
   localparam logic [TextW-1:0] ChQuote = 8'h22;
   localparam logic [TextW-1:0] ChColon = 8'h3A;
   localparam logic [TextW-1:0] ChSpace = 8'h20;
   localparam logic [TextW-1:0] ChTab   = 8'h09;
   localparam logic [TextW-1:0] ChLf    = 8'h0A;
   localparam logic [TextW-1:0] ChCr    = 8'h0D;
   localparam logic [TextW-1:0] ChZero  = 8'h30;
   localparam logic [TextW-1:0] ChNine  = 8'h39;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_COLON  = 3'd1,
      PH_WS     = 3'd2,
      PH_DIGITS = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [MatchW-1:0]  match_count;
      logic [ValueW-1:0]  accumulated;
   } scan_state_type;

   typedef struct packed {
      logic               found;
      logic [ValueW-1:0]  seq_value;
   } result_type;

   // Characters of the fixed key, first to last.
   function automatic logic [TextW-1:0] key_char(input logic [3:0] idx);
      logic [TextW-1:0] ch;
      case (idx)
         4'd0:    ch = 8'h61; // a
         4'd1:    ch = 8'h63; // c
         4'd2:    ch = 8'h63; // c
         4'd3:    ch = 8'h65; // e
         4'd4:    ch = 8'h70; // p
         4'd5:    ch = 8'h74; // t
         4'd6:    ch = 8'h65; // e
         4'd7:    ch = 8'h64; // d
         4'd8:    ch = 8'h5F; // _
         4'd9:    ch = 8'h74; // t
         4'd10:   ch = 8'h68; // h
         4'd11:   ch = 8'h72; // r
         4'd12:   ch = 8'h6F; // o
         4'd13:   ch = 8'h75; // u
         4'd14:   ch = 8'h67; // g
         4'd15:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_ws(input logic [TextW-1:0] c);
      return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
   endfunction

   function automatic logic is_digit(input logic [TextW-1:0] c);
      return (c >= ChZero) && (c <= ChNine);
   endfunction

endpackage

// ===== rtl/jkue_if.sv =====
// Valid/ready channel interfaces for the text input and the result output.
interface jkue_req_if;
   logic                       valid;
   logic                       ready;
   logic [jkue_pkg::TextW-1:0] text_byte;
   logic                       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jkue_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [jkue_pkg::ValueW-1:0] seq_value;

   modport source (output valid, output found, output seq_value, input ready);
   modport sink   (input valid, input found, input seq_value, output ready);
endinterface

// ===== rtl/json_key_uint_extractor.sv =====
// A result beat is valid in the cycle after the byte that decides it is accepted.
// Throughput: one text byte per cycle; ready drops only while a result beat is stalled.
// The scan state register and the output register are the only stages of the design.
// Reset is synchronous and active high; it clears the scan state and the output valid.
// A terminator beat also returns the scan state to its reset value.
module json_key_uint_extractor (
   input  logic       clock,
   input  logic       reset,
   jkue_req_if.sink   req_bus,
   jkue_rsp_if.source rsp_bus
);
   import jkue_pkg::*;

`include "json_key_uint_extractor_assert.svh"

   // Scan state: phase, count of key characters matched, digits gathered so far.
   scan_state_type state_ff;
   scan_state_type state_in;

   logic       accept;
   logic       emit;
   logic       can_load;
   result_type result;

   // A new byte is taken whenever the output register is free or drains this cycle,
   // so bytes stream back to back while the result side keeps up.
   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && req_bus.ready;

   jkue_step u_step (
      .cur_state   (state_ff),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .next_state  (state_in),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_SEARCH;
         state_ff.match_count <= '0;
         state_ff.accumulated <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Only an accepted byte that decides the outcome loads a result beat.
   jkue_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && emit),
      .result   (result),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

   // A failure beat always carries a zero value.
   `JKUE_ASSERT_IMPLY(a_fail_zero, rsp_bus.valid && !rsp_bus.found, rsp_bus.seq_value == '0)
   // A terminator returns the scanner to its reset state.
   `JKUE_ASSERT_NEXT(a_eot_resets, accept && req_bus.end_of_text, state_ff.phase == PH_SEARCH && state_ff.match_count == '0)
   // Once a result is out, nothing but the terminator may produce another.
   `JKUE_ASSERT_IMPLY(a_one_result, accept && state_ff.phase == PH_DONE && !req_bus.end_of_text, !emit)
   // Emitting a result moves the scanner to the done phase unless the text ended.
   `JKUE_ASSERT_NEXT(a_emit_done, accept && emit && !req_bus.end_of_text, state_ff.phase == PH_DONE)

endmodule

// ===== rtl/jkue_step.sv =====
// Next-state and result logic for one text byte of the key scanner.
module jkue_step (
   input  jkue_pkg::scan_state_type           cur_state,
   input  logic [jkue_pkg::TextW-1:0]         text_byte,
   input  logic                               end_of_text,
   output jkue_pkg::scan_state_type           next_state,
   output logic                               emit,
   output jkue_pkg::result_type               result
);
   import jkue_pkg::*;

   logic [ValueW+3:0]  scaled;
   logic               overflow;
   logic [MatchW-1:0]  matched;
   logic               fin_emit;
   result_type         fin_result;

   // accumulated * 10 + digit, kept four bits wider to see an overflow.
   assign scaled = {1'b0, cur_state.accumulated, 3'b000}
                 + {3'b000, cur_state.accumulated, 1'b0}
                 + {{ValueW{1'b0}}, text_byte[3:0]};
   assign overflow = |scaled[ValueW+3:ValueW];

   // Result that a terminator or a zero byte produces.
   always_comb begin
      fin_emit   = 1'b0;
      fin_result = '0;
      case (cur_state.phase)
         PH_DIGITS: begin
            fin_emit             = 1'b1;
            fin_result.found     = 1'b1;
            fin_result.seq_value = cur_state.accumulated;
         end
         PH_SEARCH, PH_COLON, PH_WS: begin
            fin_emit = 1'b1;
         end
         default: begin
            fin_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      next_state = cur_state;
      emit       = 1'b0;
      result     = '0;
      matched    = '0;
      if (end_of_text) begin
         emit                   = fin_emit;
         result                 = fin_result;
         next_state.phase       = PH_SEARCH;
         next_state.match_count = '0;
         next_state.accumulated = '0;
      end else if (text_byte == ChNul) begin
         emit   = fin_emit;
         result = fin_result;
         if (fin_emit) begin
            next_state.phase = PH_DONE;
         end
      end else begin
         case (cur_state.phase)
            PH_SEARCH: begin
               if (!cur_state.match_count[MatchW-1] &&
                   text_byte == key_char(cur_state.match_count[MatchW-2:0])) begin
                  matched = cur_state.match_count + MatchW'(1);
               end else if (text_byte == key_char(4'd0)) begin
                  matched = MatchW'(1);
               end else begin
                  matched = '0;
               end
               next_state.match_count = matched;
               if (matched[MatchW-1]) begin
                  next_state.phase = PH_COLON;
               end
            end
            PH_COLON: begin
               if (text_byte == ChColon) begin
                  next_state.phase = PH_WS;
               end else if (!(text_byte == ChQuote || is_ws(text_byte))) begin
                  emit             = 1'b1;
                  next_state.phase = PH_DONE;
               end
            end
            PH_WS: begin
               if (is_digit(text_byte)) begin
                  next_state.accumulated = {{(ValueW-4){1'b0}}, text_byte[3:0]};
                  next_state.phase       = PH_DIGITS;
               end else if (!is_ws(text_byte)) begin
                  emit             = 1'b1;
                  next_state.phase = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (!is_digit(text_byte)) begin
                  emit             = 1'b1;
                  result.found     = 1'b1;
                  result.seq_value = cur_state.accumulated;
                  next_state.phase = PH_DONE;
               end else if (overflow) begin
                  emit             = 1'b1;
                  next_state.phase = PH_DONE;
               end else begin
                  next_state.accumulated = scaled[ValueW-1:0];
               end
            end
            default: begin
               // A result was already delivered: bytes wait for the terminator.
               next_state = cur_state;
            end
         endcase
      end
   end

endmodule

// ===== rtl/jkue_rsp_reg.sv =====
// Output register that holds one result beat until the sink takes it.
module jkue_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  jkue_pkg::result_type result,
   output logic                 can_load,
   jkue_rsp_if.source           rsp_bus
);
   import jkue_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.found     = data_ff.found;
   assign rsp_bus.seq_value = data_ff.seq_value;

endmodule

// ===== tb/json_key_uint_extractor_test.sv =====
// Self-checking testbench for the JSON key extractor: directed texts, then random texts.
module json_key_uint_extractor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import jkue_pkg::*;

   // The run stops with a failure if this many cycles go by.
   localparam int CycleLimit = 200000;
   // Random bytes to send after the directed texts.
   localparam int RandomBeats = 800;
   // Cycles to wait after the last expected result before the final check.
   localparam int SettleCycles = 4;
   // Mismatches beyond this count are only counted, not printed.
   localparam int ReportLimit = 10;
   // The key that the scanner looks for.
   localparam string KeyHead = "accepted";
   localparam string KeyText = {KeyHead, "_through"};
   // In the directed texts this character stands for the whole key.
   localparam byte KeyMark = 8'h40;

   logic clock = 1'b0;
   logic reset;

   jkue_req_if req_bus ();
   jkue_rsp_if rsp_bus ();

   json_key_uint_extractor dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // One row of the directed table. A row with pinned set carries its result
   // typed in by hand; that result then stands in for the predicted one.
   typedef struct {
      string       text;
      int          nul_at;   // index in the expanded text for a zero byte, -1 for none
      bit          pinned;
      logic        found;
      logic [31:0] value;
   } text_case_type;

   text_case_type directed_cases [17] = '{
      '{"", -1, 1'b1, 1'b0, 32'd0},
      '{"{\"@\":0}", -1, 1'b1, 1'b1, 32'd0},
      '{"\"@\" : 4294967295", -1, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{"@:4294967296,", -1, 1'b1, 1'b0, 32'd0},
      '{"@:42949672950", -1, 1'b1, 1'b0, 32'd0},
      '{"@ x:5", -1, 1'b1, 1'b0, 32'd0},
      '{"@: -5", -1, 1'b1, 1'b0, 32'd0},
      '{"@:", -1, 1'b1, 1'b0, 32'd0},
      '{"accepted_thro", -1, 1'b1, 1'b0, 32'd0},
      '{"accepted_throuGh:1", -1, 1'b1, 1'b0, 32'd0},
      '{"@:5", 0, 1'b1, 1'b0, 32'd0},
      '{"@:77 88", 19, 1'b0, 1'b0, 32'd0},
      '{"xaccacce@:12}", -1, 1'b0, 1'b0, 32'd0},
      '{"a@:3", -1, 1'b0, 1'b0, 32'd0},
      '{"accepted_@\"\" \t:\r\n 00042 x", -1, 1'b0, 1'b0, 32'd0},
      '{"@:3,\"@\":9", -1, 1'b0, 1'b0, 32'd0},
      '{"\377@:1\200", -1, 1'b0, 1'b0, 32'd0}
   };

   string boundary_numbers [8] = '{
      "4294967295", "4294967296", "4294967294", "4294967300",
      "42949672950", "00004294967295", "0", "9999999999"
   };

   // Predictor state, a copy of the scanner kept in step with accepted beats.
   phase_type   scan_phase = PH_SEARCH;
   logic [4:0]  key_matched = '0;
   logic [31:0] digit_value = '0;

   // Results the block owes us, oldest first.
   result_type  awaited_results [$];
   result_type  oldest_result;

   // Hand-typed result of the directed row currently being sent.
   bit          pin_on = 1'b0;
   result_type  pin_result;

   logic [7:0]  text_buf [$];
   bit          idling = 1'b0;
   int unsigned cycle_count = 0;
   int          error_count = 0;
   int          beats_sent = 0;
   int          texts_sent = 0;
   int          results_seen = 0;
   int          found_count = 0;

   function automatic bit blank(input logic [7:0] ch);
      return ch == ChSpace || ch == ChTab || ch == ChLf || ch == ChCr;
   endfunction

   function automatic bit numeral(input logic [7:0] ch);
      return ch >= ChZero && ch <= ChNine;
   endfunction

   // Queue one result and close the text for further bytes.
   function automatic void owe_result(input logic ok, input logic [31:0] value);
      result_type r;
      r.found = ok;
      r.seq_value = ok ? value : '0;
      if (pin_on) begin
         r = pin_result;
      end
      awaited_results.push_back(r);
      scan_phase = PH_DONE;
   endfunction

   // End of the text, by terminator or zero byte: a number in progress is a
   // success, any earlier phase a failure, and a closed text owes nothing.
   function automatic void close_text();
      case (scan_phase)
         PH_DIGITS: owe_result(1'b1, digit_value);
         PH_SEARCH, PH_COLON, PH_WS: owe_result(1'b0, '0);
         default: ;
      endcase
   endfunction

   // Advance the predictor by one accepted beat.
   function automatic void scan_byte(input logic [7:0] ch, input logic eot);
      logic [35:0] wide;
      if (eot) begin
         close_text();
         scan_phase = PH_SEARCH;
         key_matched = '0;
         digit_value = '0;
         return;
      end
      if (scan_phase == PH_DONE) begin
         return;
      end
      if (ch == ChNul) begin
         close_text();
         return;
      end
      case (scan_phase)
         PH_SEARCH: begin
            // The letter a appears only at the head of the key, so a broken
            // match can only restart on an a.
            if (key_matched < KeyLen && ch == KeyText[key_matched]) begin
               key_matched = key_matched + 1'b1;
            end else begin
               key_matched = (ch == KeyText[0]) ? 5'd1 : 5'd0;
            end
            if (key_matched >= KeyLen) begin
               scan_phase = PH_COLON;
            end
         end
         PH_COLON: begin
            if (ch == ChColon) begin
               scan_phase = PH_WS;
            end else if (ch != ChQuote && !blank(ch)) begin
               owe_result(1'b0, '0);
            end
         end
         PH_WS: begin
            if (numeral(ch)) begin
               digit_value = 32'(ch - ChZero);
               scan_phase = PH_DIGITS;
            end else if (!blank(ch)) begin
               owe_result(1'b0, '0);
            end
         end
         default: begin
            if (numeral(ch)) begin
               wide = digit_value * 36'd10 + 36'(ch - ChZero);
               if (wide > 36'hFFFF_FFFF) begin
                  owe_result(1'b0, '0);
               end else begin
                  digit_value = wide[31:0];
               end
            end else begin
               owe_result(1'b1, digit_value);
            end
         end
      endcase
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= ReportLimit) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
   endfunction

   // A random separator: whitespace, and after the key a quote as well.
   function automatic logic [7:0] gap_char(input bit with_quote);
      case ($urandom_range(with_quote ? 0 : 1, 4))
         0: return ChQuote;
         1: return ChSpace;
         2: return ChTab;
         3: return ChLf;
         default: return ChCr;
      endcase
   endfunction

   function automatic void push_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endfunction

   // Build one random text in text_buf. Most texts carry the whole key and a
   // number with random spacing around them, so that the digit run is reached
   // often; the rest are noise, cut-off keys and texts with one byte spoiled.
   function automatic void compose_random_text();
      int shape;
      int count;
      int pick;
      text_buf.delete();
      shape = $urandom_range(0, 19);
      // Noise ahead of the key, often with a false start of the key itself.
      repeat ($urandom_range(0, 4)) begin
         pick = $urandom_range(0, 3);
         if (pick == 0) begin
            push_string(KeyText.substr(0, $urandom_range(0, KeyLen - 2)));
         end else if (pick == 1) begin
            text_buf.push_back(8'($urandom_range(1, 255)));
         end else begin
            text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         end
      end
      if (shape < 2) begin
         repeat ($urandom_range(0, 30)) text_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (shape < 4) begin
         push_string(KeyText.substr(0, $urandom_range(0, KeyLen - 2)));
         repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(1, 255)));
         return;
      end
      push_string(KeyText);
      repeat ($urandom_range(0, 3)) text_buf.push_back(gap_char(1'b1));
      if ($urandom_range(0, 9) == 0) begin
         text_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
         text_buf.push_back(ChColon);
      end
      repeat ($urandom_range(0, 3)) text_buf.push_back(gap_char(1'b0));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         count = (pick < 4) ? $urandom_range(1, 4) : $urandom_range(5, 10);
         repeat (count) text_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
      end else if (pick < 9) begin
         push_string(boundary_numbers[$urandom_range(0, 7)]);
      end else begin
         text_buf.push_back(8'($urandom_range(1, 255)));
      end
      // What ends the number: nothing, a zero byte, punctuation or anything.
      case ($urandom_range(0, 4))
         0: ;
         1: text_buf.push_back(ChNul);
         2: text_buf.push_back(8'h2C);
         3: text_buf.push_back(8'h7D);
         default: text_buf.push_back(8'($urandom_range(1, 255)));
      endcase
      repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
      if (shape == 4) begin
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endfunction

   // Offer one beat and return at the edge that takes it. Readiness is read
   // at the falling edge, clear of the rising edge.
   task automatic put_beat(input logic [7:0] ch, input logic eot);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= ch;
      req_bus.end_of_text <= eot;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      beats_sent++;
   endtask

   // Send text_buf followed by a terminator beat with a random byte on it.
   task automatic send_text();
      foreach (text_buf[i]) put_beat(text_buf[i], 1'b0);
      put_beat(8'($urandom_range(0, 255)), 1'b1);
      texts_sent++;
   endtask

   // Result side: ready drops in random bursts while idling
   // is on, and stays high otherwise.
   initial begin : result_ready
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b1;
            stall_left = 0;
         end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (idling && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Both channels are watched at the falling edge: a beat that shows valid
   // and ready there is taken at the next rising edge. Input beats feed the
   // predictor; result beats are checked against the oldest owed result.
   always @(negedge clock) begin
      if (reset) begin
         scan_phase = PH_SEARCH;
         key_matched = '0;
         digit_value = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            scan_byte(req_bus.text_byte, req_bus.end_of_text);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("result found=%0b value=%0d with none expected",
                                      rsp_bus.found, rsp_bus.seq_value));
            end else begin
               oldest_result = awaited_results.pop_front();
               if (oldest_result.found) begin
                  found_count++;
               end
               if (rsp_bus.found !== oldest_result.found) begin
                  note_failure($sformatf("found expected %0b, got %0b",
                                         oldest_result.found, rsp_bus.found));
               end
               if (rsp_bus.seq_value !== oldest_result.seq_value) begin
                  note_failure($sformatf("seq_value expected %0d, got %0d",
                                         oldest_result.seq_value, rsp_bus.seq_value));
               end
            end
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CycleLimit);
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, awaited_results.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      req_bus.valid <= 1'b0;
      req_bus.text_byte <= '0;
      req_bus.end_of_text <= 1'b0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed texts: key restarts, every way to fail, both extremes of the
      // value, zero bytes, a second key after the first and bytes after a result.
      foreach (directed_cases[row]) begin
         idling = ($urandom_range(0, 1) != 0);
         text_buf.delete();
         for (int i = 0; i < directed_cases[row].text.len(); i++) begin
            if (directed_cases[row].text[i] == KeyMark) begin
               push_string(KeyText);
            end else begin
               text_buf.push_back(directed_cases[row].text[i]);
            end
         end
         if (directed_cases[row].nul_at >= 0) begin
            text_buf.insert(directed_cases[row].nul_at, ChNul);
         end
         pin_on = directed_cases[row].pinned;
         pin_result.found = directed_cases[row].found;
         pin_result.seq_value = directed_cases[row].value;
         send_text();
         pin_on = 1'b0;
      end

      // Random texts. Idling is set per text, and switched off entirely for
      // the last sixth of the run so that back-to-back traffic is seen too.
      random_start = beats_sent;
      while (beats_sent - random_start < RandomBeats) begin
         idling = (beats_sent - random_start < RandomBeats * 5 / 6) &&
                  ($urandom_range(0, 3) != 0);
         compose_random_text();
         send_text();
      end
      req_bus.valid <= 1'b0;
      idling = 1'b0;

      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
      error_count += awaited_results.size();

      $display("Sent %0d texts in %0d beats; checked %0d results, %0d of them with a number.",
               texts_sent, beats_sent, results_seen, found_count);
      $display("Mismatches: %0d.", error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== json_key_uint_extractor.f =====
+incdir+rtl
rtl/jkue_pkg.sv
rtl/jkue_if.sv
rtl/jkue_step.sv
rtl/jkue_rsp_reg.sv
rtl/json_key_uint_extractor.sv
tb/json_key_uint_extractor_test.sv
